// ----- hw/rtl/cwc_pkg.sv -----
// Shared types and constants for the color window centroid block.
// Depends on nothing; every other file refers to it by scoped names.
package cwc_pkg;

  // Field widths
  localparam int CH_W       = 8;
  localparam int WIN_POS_W  = 11;
  localparam int WIN_SIZE_W = 9;
  localparam int BGR_W      = 24;
  localparam int SUM_W      = 24;
  localparam int TALLY_W    = 17;
  localparam int CENT_W     = 8;
  localparam int NORM_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Frame record queue depth
  localparam int QDEPTH = 2;

  // Divider: remainder stays below the divisor, steps per kind of quotient
  localparam int REM_W          = TALLY_W;
  localparam int DIV_STEPS_CENT = SUM_W;
  localparam int DIV_STEPS_NORM = NORM_W;
  localparam int STEP_W         = $clog2(DIV_STEPS_CENT + 1);

  // Register reset values
  localparam logic [WIN_POS_W-1:0]  RST_WIN_LEFT   = 11'd215;
  localparam logic [WIN_POS_W-1:0]  RST_WIN_TOP    = 11'd100;
  localparam logic [WIN_SIZE_W-1:0] RST_WIN_SIZE   = 9'd220;
  localparam logic [BGR_W-1:0]      RST_LOWER_BGR  = 24'h647DB4;
  localparam logic [BGR_W-1:0]      RST_UPPER_BGR  = 24'hFFFFFF;
  localparam logic [TALLY_W-1:0]    RST_MIN_PIXELS = 17'd800;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_LEFT   = 3'd0,
    CFG_WIN_TOP    = 3'd1,
    CFG_WIN_SIZE   = 3'd2,
    CFG_LOWER_BGR  = 3'd3,
    CFG_UPPER_BGR  = 3'd4,
    CFG_MIN_PIXELS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_POS_W-1:0]  win_left;
    logic [WIN_POS_W-1:0]  win_top;
    logic [WIN_SIZE_W-1:0] win_size;
    logic [BGR_W-1:0]      lower_bgr;
    logic [BGR_W-1:0]      upper_bgr;
    logic [TALLY_W-1:0]    min_pixels;
  } cfg_t;

  // Totals of one finished frame
  typedef struct packed {
    logic [SUM_W-1:0]   row_sum;
    logic [SUM_W-1:0]   col_sum;
    logic [TALLY_W-1:0] tally;
    logic [TALLY_W-1:0] min_pixels;
  } rec_t;

  typedef struct packed {
    logic               start;
    logic               norm;
    logic [SUM_W-1:0]   num;
    logic [TALLY_W-1:0] den;
    logic [REM_W-1:0]   rem0;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- hw/rtl/cwc_front.sv -----
// Pixel front end: tracks raster position, classifies pixels, accumulates sums.
// Depends on cwc_pkg; pushes one frame record per frame-end beat.
module cwc_front #(
  parameter int MAX_WINDOW    = 256,
  parameter int MAX_FRAME_DIM = 2048,
  localparam int SW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cwc_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  input  logic [cwc_pkg::CH_W-1:0]      blue_i,
  input  logic [cwc_pkg::CH_W-1:0]      green_i,
  input  logic [cwc_pkg::CH_W-1:0]      red_i,
  input  logic                          line_start_i,
  input  logic                          frame_end_i,
  input  logic                          full_i,
  output logic                          push_o,
  output cwc_pkg::rec_t                 rec_o,
  output logic [SW-1:0]                 size_o
);

  localparam int PW = $clog2(MAX_FRAME_DIM);
  localparam int AW = cwc_pkg::WIN_POS_W;
  localparam int MW = (PW > AW) ? PW : AW;
  localparam int CW = ((MW > SW) ? MW : SW) + 1;
  localparam int SUM_W = cwc_pkg::SUM_W;
  localparam int TALLY_W = cwc_pkg::TALLY_W;
  localparam logic [PW:0] POS_MAX = (PW + 1)'(MAX_FRAME_DIM - 1);

  function automatic logic chan_ok(input logic [7:0] ch, input logic [7:0] lo,
                                   input logic [7:0] hi);
    return (ch >= lo) && (ch <= hi);
  endfunction

  logic [PW-1:0]      row_q, row_d, col_q, col_d;
  logic [SUM_W-1:0]   rsum_q, rsum_d, csum_q, csum_d;
  logic [TALLY_W-1:0] tally_q, tally_d;

  logic               accept;
  logic [PW:0]        row_inc, col_inc;
  logic [PW-1:0]      row_sat, r, c, col_next;
  logic [CW-1:0]      size_w, ws_w, r_w, c_w, top_w, left_w, rr_w, cc_w;
  logic               in_win, color_ok, match;
  logic [SUM_W:0]     rsum_add, csum_add;
  logic [SUM_W-1:0]   rsum_n, csum_n;
  logic [TALLY_W-1:0] tally_n;

  assign accept = in_valid_i && !full_i;

  // Locate the pixel in the frame
  always_comb begin
    row_inc = {1'b0, row_q} + (PW + 1)'(1);
    row_sat = (row_inc > POS_MAX) ? POS_MAX[PW-1:0] : row_inc[PW-1:0];
    if (line_start_i) begin
      c = '0;
      r = (col_q != '0) ? row_sat : row_q;
    end else begin
      c = col_q;
      r = row_q;
    end
    col_inc  = {1'b0, c} + (PW + 1)'(1);
    col_next = (col_inc > POS_MAX) ? POS_MAX[PW-1:0] : col_inc[PW-1:0];
  end

  // Clamp the window side and classify the pixel
  always_comb begin
    ws_w = CW'(cfg_i.win_size);
    if (cfg_i.win_size == '0) begin
      size_w = CW'(1);
    end else if (ws_w > CW'(MAX_WINDOW)) begin
      size_w = CW'(MAX_WINDOW);
    end else begin
      size_w = ws_w;
    end
    r_w    = CW'(r);
    c_w    = CW'(c);
    top_w  = CW'(cfg_i.win_top);
    left_w = CW'(cfg_i.win_left);
    in_win = (r_w >= top_w) && (r_w < top_w + size_w) &&
             (c_w >= left_w) && (c_w < left_w + size_w);
    color_ok = chan_ok(blue_i,  cfg_i.lower_bgr[23:16], cfg_i.upper_bgr[23:16]) &&
               chan_ok(green_i, cfg_i.lower_bgr[15:8],  cfg_i.upper_bgr[15:8]) &&
               chan_ok(red_i,   cfg_i.lower_bgr[7:0],   cfg_i.upper_bgr[7:0]);
    match = in_win && color_ok;
    rr_w  = r_w - top_w;
    cc_w  = c_w - left_w;
  end

  // Accumulate with saturation
  always_comb begin
    rsum_add = {1'b0, rsum_q} + (SUM_W + 1)'(rr_w);
    csum_add = {1'b0, csum_q} + (SUM_W + 1)'(cc_w);
    rsum_n   = rsum_q;
    csum_n   = csum_q;
    tally_n  = tally_q;
    if (match) begin
      rsum_n = rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
      csum_n = csum_add[SUM_W] ? '1 : csum_add[SUM_W-1:0];
      if (tally_q != '1) begin
        tally_n = tally_q + TALLY_W'(1);
      end
    end
  end

  // Advance state; clear it after the frame-end beat
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    rsum_d  = rsum_q;
    csum_d  = csum_q;
    tally_d = tally_q;
    if (accept) begin
      if (frame_end_i) begin
        row_d   = '0;
        col_d   = '0;
        rsum_d  = '0;
        csum_d  = '0;
        tally_d = '0;
      end else begin
        row_d   = r;
        col_d   = col_next;
        rsum_d  = rsum_n;
        csum_d  = csum_n;
        tally_d = tally_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      rsum_q  <= '0;
      csum_q  <= '0;
      tally_q <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      rsum_q  <= rsum_d;
      csum_q  <= csum_d;
      tally_q <= tally_d;
    end
  end

  // Hand the finished frame to the queue
  assign push_o           = accept && frame_end_i;
  assign rec_o.row_sum    = rsum_n;
  assign rec_o.col_sum    = csum_n;
  assign rec_o.tally      = tally_n;
  assign rec_o.min_pixels = cfg_i.min_pixels;
  assign size_o           = size_w[SW-1:0];

endmodule

// ----- hw/rtl/cwc_fifo.sv -----
// Short queue of finished frame records between front and back.
// Depends on cwc_pkg for its depth.
module cwc_fifo #(
  parameter int DATA_W = 83
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] din_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] dout_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int DEPTH = cwc_pkg::QDEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// ----- hw/rtl/cwc_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, shared by all quotients.
// Depends on cwc_pkg for its request and response structs.
module cwc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cwc_pkg::div_req_t req_i,
  output cwc_pkg::div_rsp_t rsp_o
);

  localparam int SUM_W  = cwc_pkg::SUM_W;
  localparam int REM_W  = cwc_pkg::REM_W;
  localparam int STEP_W = cwc_pkg::STEP_W;

  logic [REM_W-1:0]  rem_q, rem_d, den_q, den_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [REM_W:0]    trial, diff;
  logic              ge;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.rem0;
      den_d  = req_i.den;
      quo_d  = req_i.num;
      cnt_d  = req_i.norm ? STEP_W'(cwc_pkg::DIV_STEPS_NORM)
                          : STEP_W'(cwc_pkg::DIV_STEPS_CENT);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ge};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ----- hw/rtl/cwc_back.sv -----
// Back end: turns a frame record into centroids and normalized values.
// Depends on cwc_pkg and cwc_div; holds the result until the receiver takes it.
module cwc_back #(
  parameter int MAX_WINDOW = 256,
  localparam int SW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  cwc_pkg::rec_t                        rec_i,
  input  logic [SW-1:0]                        size_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cwc_pkg::CENT_W-1:0]           row_centroid_o,
  output logic [cwc_pkg::CENT_W-1:0]           col_centroid_o,
  output logic signed [cwc_pkg::NORM_W-1:0]    row_normalized_o,
  output logic signed [cwc_pkg::NORM_W-1:0]    col_normalized_o,
  output logic [cwc_pkg::TALLY_W-1:0]          match_count_o,
  output logic                                 ball_found_o
);

  localparam int SUM_W   = cwc_pkg::SUM_W;
  localparam int TALLY_W = cwc_pkg::TALLY_W;
  localparam int NORM_W  = cwc_pkg::NORM_W;
  localparam int REM_W   = cwc_pkg::REM_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ROW_DIV = 6'b000010,
    ST_COL_DIV = 6'b000100,
    ST_ROW_NRM = 6'b001000,
    ST_COL_NRM = 6'b010000,
    ST_DONE    = 6'b100000
  } back_state_e;

  // Q1.15 value from the quotient, saturated when the centroid reaches the size
  function automatic logic [NORM_W-1:0] to_q15(input logic [SUM_W-1:0] avg,
                                               input logic [SUM_W-1:0] size,
                                               input logic [SUM_W-1:0] quot);
    logic [NORM_W-1:0] q;
    q = (avg >= size) ? '1 : quot[NORM_W-1:0];
    return {~q[NORM_W-1], q[NORM_W-2:0]};
  endfunction

  back_state_e        state_q, state_d;
  logic               start_q, start_d;
  logic [SUM_W-1:0]   rsum_q, rsum_d, csum_q, csum_d;
  logic [TALLY_W-1:0] tally_q, tally_d, minp_q, minp_d;
  logic [SW-1:0]      size_q, size_d;
  logic               found_q, found_d;
  logic [SUM_W-1:0]   ravg_q, ravg_d, cavg_q, cavg_d;
  logic [NORM_W-1:0]  rnorm_q, rnorm_d, cnorm_q, cnorm_d;
  logic [SUM_W-1:0]   size_ext, half_ext, avg_sel;
  logic               rec_found, is_norm;
  cwc_pkg::div_req_t  div_req;
  cwc_pkg::div_rsp_t  div_rsp;

  assign size_ext  = SUM_W'(size_q);
  assign half_ext  = SUM_W'(size_i >> 1);
  assign rec_found = (rec_i.tally != '0) && (rec_i.tally >= rec_i.min_pixels);
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;

  // Select divider operands by step; normalizing shifts zeros in below the centroid
  always_comb begin
    is_norm = (state_q == ST_ROW_NRM) || (state_q == ST_COL_NRM);
    avg_sel = (state_q == ST_COL_NRM) ? cavg_q : ravg_q;
    div_req.start = start_q;
    div_req.norm  = is_norm;
    div_req.num   = is_norm ? '0 : ((state_q == ST_COL_DIV) ? csum_q : rsum_q);
    div_req.den   = is_norm ? TALLY_W'(size_q) : tally_q;
    div_req.rem0  = is_norm ? avg_sel[REM_W-1:0] : '0;
  end

  cwc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequence the four quotients, or only the two normalized values for a frame without a blob
  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    rsum_d  = rsum_q;
    csum_d  = csum_q;
    tally_d = tally_q;
    minp_d  = minp_q;
    size_d  = size_q;
    found_d = found_q;
    ravg_d  = ravg_q;
    cavg_d  = cavg_q;
    rnorm_d = rnorm_q;
    cnorm_d = cnorm_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          rsum_d  = rec_i.row_sum;
          csum_d  = rec_i.col_sum;
          tally_d = rec_i.tally;
          minp_d  = rec_i.min_pixels;
          size_d  = size_i;
          found_d = rec_found;
          start_d = 1'b1;
          if (rec_found) begin
            state_d = ST_ROW_DIV;
          end else begin
            ravg_d  = half_ext;
            cavg_d  = half_ext;
            state_d = ST_ROW_NRM;
          end
        end
      end
      ST_ROW_DIV: begin
        if (div_rsp.done) begin
          ravg_d  = div_rsp.quot;
          start_d = 1'b1;
          state_d = ST_COL_DIV;
        end
      end
      ST_COL_DIV: begin
        if (div_rsp.done) begin
          cavg_d  = div_rsp.quot;
          start_d = 1'b1;
          state_d = ST_ROW_NRM;
        end
      end
      ST_ROW_NRM: begin
        if (div_rsp.done) begin
          rnorm_d = to_q15(ravg_q, size_ext, div_rsp.quot);
          start_d = 1'b1;
          state_d = ST_COL_NRM;
        end
      end
      ST_COL_NRM: begin
        if (div_rsp.done) begin
          cnorm_d = to_q15(cavg_q, size_ext, div_rsp.quot);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsum_q  <= rsum_d;
    csum_q  <= csum_d;
    tally_q <= tally_d;
    minp_q  <= minp_d;
    size_q  <= size_d;
    ravg_q  <= ravg_d;
    cavg_q  <= cavg_d;
    rnorm_q <= rnorm_d;
    cnorm_q <= cnorm_d;
  end

  // Drive the result beat
  assign out_valid_o      = (state_q == ST_DONE);
  assign row_centroid_o   = ravg_q[cwc_pkg::CENT_W-1:0];
  assign col_centroid_o   = cavg_q[cwc_pkg::CENT_W-1:0];
  assign row_normalized_o = $signed(rnorm_q);
  assign col_normalized_o = $signed(cnorm_q);
  assign match_count_o    = tally_q;
  assign ball_found_o     = found_q;

`ifndef SYNTH
  a_start_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> !start_q)
    else $error("divider start held longer than one cycle");

  a_pop_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (start_q && (state_q == ST_ROW_DIV || state_q == ST_ROW_NRM)))
    else $error("popped record did not launch a quotient");

  a_done_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DONE) |-> $past(state_q == ST_COL_NRM))
    else $error("result shown before the last quotient");

  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_q) |-> (tally_q != '0 && tally_q >= minp_q))
    else $error("detection flagged with too few pixels");
`endif

endmodule

// ----- hw/rtl/color_window_centroid.sv -----
// Top level of the color window centroid block: configuration registers,
// pixel front end, frame record queue and divider back end.
// Depends on cwc_pkg, cwc_front, cwc_fifo, cwc_back.
//
// Usage:
//   Pixels enter as beats on the input channel (in_valid_i / in_stall_o), one
//   per cycle while in_stall_o is low, in raster order with line_start_i and
//   frame_end_i marks. in_stall_o rises only while two finished frames wait in
//   the record queue. Each frame-end beat yields one result beat on the output channel
//   (out_valid_o / out_stall_i): centroids, Q1.15 normalized values, match
//   count and the found flag.
//   For each result the back end pops the record, then runs the shared
//   one-bit-per-cycle divider: 24 steps per centroid and 16 per normalized
//   value, with a handoff between quotients; the centre fallback skips the
//   two centroid divisions.
//   A held result waits in the back end while the front keeps taking pixels;
//   only a full queue stalls the input.
//   The user must write registers (cfg_we_i / cfg_idx_i / cfg_data_i) only while
//   the block is idle; the block itself does not enforce it. Unknown indexes are ignored.
//   Reset clears position, sums, queue and sequencer and reloads the register
//   defaults; no clearing pass is needed.
module color_window_centroid #(
  parameter int MAX_WINDOW    = 256,
  parameter int MAX_FRAME_DIM = 2048
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cwc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [cwc_pkg::CH_W-1:0]             blue_i,
  input  logic [cwc_pkg::CH_W-1:0]             green_i,
  input  logic [cwc_pkg::CH_W-1:0]             red_i,
  input  logic                                 line_start_i,
  input  logic                                 frame_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cwc_pkg::CENT_W-1:0]           row_centroid_o,
  output logic [cwc_pkg::CENT_W-1:0]           col_centroid_o,
  output logic signed [cwc_pkg::NORM_W-1:0]    row_normalized_o,
  output logic signed [cwc_pkg::NORM_W-1:0]    col_normalized_o,
  output logic [cwc_pkg::TALLY_W-1:0]          match_count_o,
  output logic                                 ball_found_o
);

  localparam int SW    = $clog2(MAX_WINDOW + 1);
  localparam int RW    = $bits(cwc_pkg::rec_t);
  localparam int REC_W = RW + SW;

  cwc_pkg::cfg_t      cfg_q, cfg_d;
  logic               push, pop, full, empty;
  cwc_pkg::rec_t      front_rec, back_rec;
  logic [SW-1:0]      front_size, back_size;
  logic [REC_W-1:0]   q_din, q_dout;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cwc_pkg::cfg_idx_e'(cfg_idx_i))
        cwc_pkg::CFG_WIN_LEFT:   cfg_d.win_left   = cfg_data_i[cwc_pkg::WIN_POS_W-1:0];
        cwc_pkg::CFG_WIN_TOP:    cfg_d.win_top    = cfg_data_i[cwc_pkg::WIN_POS_W-1:0];
        cwc_pkg::CFG_WIN_SIZE:   cfg_d.win_size   = cfg_data_i[cwc_pkg::WIN_SIZE_W-1:0];
        cwc_pkg::CFG_LOWER_BGR:  cfg_d.lower_bgr  = cfg_data_i[cwc_pkg::BGR_W-1:0];
        cwc_pkg::CFG_UPPER_BGR:  cfg_d.upper_bgr  = cfg_data_i[cwc_pkg::BGR_W-1:0];
        cwc_pkg::CFG_MIN_PIXELS: cfg_d.min_pixels = cfg_data_i[cwc_pkg::TALLY_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_left   <= cwc_pkg::RST_WIN_LEFT;
      cfg_q.win_top    <= cwc_pkg::RST_WIN_TOP;
      cfg_q.win_size   <= cwc_pkg::RST_WIN_SIZE;
      cfg_q.lower_bgr  <= cwc_pkg::RST_LOWER_BGR;
      cfg_q.upper_bgr  <= cwc_pkg::RST_UPPER_BGR;
      cfg_q.min_pixels <= cwc_pkg::RST_MIN_PIXELS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stall pixels only when the record queue is full
  assign in_stall_o = full;

  cwc_front #(
    .MAX_WINDOW    (MAX_WINDOW),
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .line_start_i (line_start_i),
    .frame_end_i  (frame_end_i),
    .full_i       (full),
    .push_o       (push),
    .rec_o        (front_rec),
    .size_o       (front_size)
  );

  // Pack size and totals into one queue word
  assign q_din     = {front_size, front_rec};
  assign back_rec  = cwc_pkg::rec_t'(q_dout[RW-1:0]);
  assign back_size = q_dout[REC_W-1:RW];

  cwc_fifo #(
    .DATA_W (REC_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (q_din),
    .pop_i   (pop),
    .dout_o  (q_dout),
    .full_o  (full),
    .empty_o (empty)
  );

  cwc_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .rec_i            (back_rec),
    .size_i           (back_size),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .row_centroid_o   (row_centroid_o),
    .col_centroid_o   (col_centroid_o),
    .row_normalized_o (row_normalized_o),
    .col_normalized_o (col_normalized_o),
    .match_count_o    (match_count_o),
    .ball_found_o     (ball_found_o)
  );

endmodule

// ----- tb/tb_top.sv -----
// Testbench for color_window_centroid: raster pixel beats in, per-frame centroid beats out.
// Depends on cwc_pkg and the block's RTL; a built-in predictor supplies expected results.
`timescale 1ns / 100ps

module tb_top;

  localparam int CH_W       = cwc_pkg::CH_W;
  localparam int CENT_W     = cwc_pkg::CENT_W;
  localparam int NORM_W     = cwc_pkg::NORM_W;
  localparam int TALLY_W    = cwc_pkg::TALLY_W;
  localparam int SUM_W      = cwc_pkg::SUM_W;
  localparam int WIN_POS_W  = cwc_pkg::WIN_POS_W;
  localparam int WIN_SIZE_W = cwc_pkg::WIN_SIZE_W;
  localparam int BGR_W      = cwc_pkg::BGR_W;
  localparam int CFG_IDX_W  = cwc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = cwc_pkg::CFG_DATA_W;

  localparam int WIN_MAX       = 256;
  localparam int FRAME_MAX     = 2048;
  localparam int SUM_MAX       = 24'hFFFFFF;
  localparam int TALLY_MAX     = 17'h1FFFF;
  localparam int RAND_ITEMS    = 400;
  localparam int RAND_RESULTS  = 40;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int IDLE_PCT      = 37;

  // Indexes outside the register map; the block ignores them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            line_start;
    logic            frame_end;
  } pixel_t;

  typedef struct {
    logic [CENT_W-1:0]        row_cent;
    logic [CENT_W-1:0]        col_cent;
    logic signed [NORM_W-1:0] row_norm;
    logic signed [NORM_W-1:0] col_norm;
    logic [TALLY_W-1:0]       count;
    logic                     found;
  } centroid_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [CH_W-1:0] blue_i = '0;
  logic [CH_W-1:0] green_i = '0;
  logic [CH_W-1:0] red_i = '0;
  logic            line_start_i = 1'b0;
  logic            frame_end_i = 1'b0;

  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [CENT_W-1:0]        row_centroid_o;
  logic [CENT_W-1:0]        col_centroid_o;
  logic signed [NORM_W-1:0] row_normalized_o;
  logic signed [NORM_W-1:0] col_normalized_o;
  logic [TALLY_W-1:0]       match_count_o;
  logic                     ball_found_o;

  color_window_centroid #(
    .MAX_WINDOW   (WIN_MAX),
    .MAX_FRAME_DIM(FRAME_MAX)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .blue_i          (blue_i),
    .green_i         (green_i),
    .red_i           (red_i),
    .line_start_i    (line_start_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .row_centroid_o  (row_centroid_o),
    .col_centroid_o  (col_centroid_o),
    .row_normalized_o(row_normalized_o),
    .col_normalized_o(col_normalized_o),
    .match_count_o   (match_count_o),
    .ball_found_o    (ball_found_o)
  );

  // Clock: 4 ns period
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Predictor copy of the registers
  logic [WIN_POS_W-1:0]  win_left = cwc_pkg::RST_WIN_LEFT;
  logic [WIN_POS_W-1:0]  win_top = cwc_pkg::RST_WIN_TOP;
  logic [WIN_SIZE_W-1:0] win_size = cwc_pkg::RST_WIN_SIZE;
  logic [BGR_W-1:0]      band_lo = cwc_pkg::RST_LOWER_BGR;
  logic [BGR_W-1:0]      band_hi = cwc_pkg::RST_UPPER_BGR;
  logic [TALLY_W-1:0]    min_match = cwc_pkg::RST_MIN_PIXELS;

  // Predictor copy of the frame state
  logic [WIN_POS_W-1:0] pos_row = '0;
  logic [WIN_POS_W-1:0] pos_col = '0;
  logic [SUM_W-1:0]     acc_row = '0;
  logic [SUM_W-1:0]     acc_col = '0;
  logic [TALLY_W-1:0]   match_tally = '0;

  pixel_t    pixel_q[$];
  centroid_t centroid_q[$];
  pixel_t    px_cur;

  int  err_count = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  int  items_queued = 0;
  int  ends_queued = 0;
  logic calm = 1'b0;

  function automatic int unsigned clamp_pos(int unsigned v);
    return (v > FRAME_MAX - 1) ? FRAME_MAX - 1 : v;
  endfunction

  function automatic logic in_band(pixel_t px);
    return px.blue >= band_lo[23:16] && px.blue <= band_hi[23:16] &&
           px.green >= band_lo[15:8] && px.green <= band_hi[15:8] &&
           px.red >= band_lo[7:0] && px.red <= band_hi[7:0];
  endfunction

  // Q1.15 of 2*avg/size-1, pinned at the top when avg reaches size
  function automatic logic [NORM_W-1:0] scale_q15(int unsigned avg, int unsigned size);
    longint q;
    q = (longint'(avg) << 16) / size;
    if (q > 65535) q = 65535;
    return NORM_W'(q - 32768);
  endfunction

  // Advance the position and sums by one pixel; on frame end queue the centroid
  function automatic void track_pixel(pixel_t px);
    int unsigned size, r, c, rr, cc, ravg, cavg;
    logic found;
    centroid_t res;
    size = win_size;
    if (size < 1) size = 1;
    if (size > WIN_MAX) size = WIN_MAX;
    if (px.line_start) begin
      c = 0;
      r = (pos_col != 0) ? clamp_pos(pos_row + 1) : pos_row;
    end else begin
      c = pos_col;
      r = pos_row;
    end
    pos_row = WIN_POS_W'(r);
    pos_col = WIN_POS_W'(clamp_pos(c + 1));
    if (r >= win_top && r < win_top + size && c >= win_left && c < win_left + size &&
        in_band(px)) begin
      rr = r - win_top;
      cc = c - win_left;
      acc_row = (acc_row + rr > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(acc_row + rr);
      acc_col = (acc_col + cc > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(acc_col + cc);
      if (match_tally != TALLY_W'(TALLY_MAX)) match_tally = match_tally + 1'b1;
    end
    if (!px.frame_end) return;
    found = (match_tally != 0) && (match_tally >= min_match);
    if (found) begin
      ravg = acc_row / match_tally;
      cavg = acc_col / match_tally;
    end else begin
      ravg = size / 2;
      cavg = size / 2;
    end
    res.row_cent = CENT_W'(ravg);
    res.col_cent = CENT_W'(cavg);
    res.row_norm = scale_q15(ravg, size);
    res.col_norm = scale_q15(cavg, size);
    res.count    = match_tally;
    res.found    = found;
    centroid_q.push_back(res);
    acc_row = '0;
    acc_col = '0;
    match_tally = '0;
    pos_row = '0;
    pos_col = '0;
  endfunction

  function automatic logic take_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s is %h, expected %h", results_seen, name, got, want));
  endtask

  // Drive pixel beats; hold each until accepted, idle at random between beats
  always @(posedge clk_i) begin : drive_pixels
    logic next_valid;
    next_valid = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      track_pixel(px_cur);
      next_valid = 1'b0;
    end
    if (!next_valid && pixel_q.size() != 0 && !take_break()) begin
      px_cur = pixel_q.pop_front();
      blue_i       <= px_cur.blue;
      green_i      <= px_cur.green;
      red_i        <= px_cur.red;
      line_start_i <= px_cur.line_start;
      frame_end_i  <= px_cur.frame_end;
      next_valid = 1'b1;
    end
    in_valid_i <= next_valid;
  end

  // Check result beats against the oldest expected centroid; stall at random
  always @(posedge clk_i) begin : check_results
    centroid_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (centroid_q.size() == 0) begin
        flag_mismatch($sformatf("result beat with no frame end pending, count %h",
                                match_count_o));
      end else begin
        want = centroid_q.pop_front();
        check_field("row_centroid", row_centroid_o, want.row_cent);
        check_field("col_centroid", col_centroid_o, want.col_cent);
        check_field("row_normalized", row_normalized_o, want.row_norm);
        check_field("col_normalized", col_normalized_o, want.col_norm);
        check_field("match_count", match_count_o, want.count);
        check_field("ball_found", ball_found_o, want.found);
      end
      results_seen++;
    end
    out_stall_i <= take_break();
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void push_px(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                  logic ls, logic fe);
    pixel_q.push_back('{b, g, r, ls, fe});
    items_queued++;
    if (fe) ends_queued++;
  endfunction

  // Mostly in-band channel values so that windows see matches
  function automatic logic [7:0] pick_channel(logic [7:0] lo, logic [7:0] hi);
    if ($urandom_range(3) != 0) return 8'($urandom_range(hi, lo));
    return 8'($urandom);
  endfunction

  // Well-formed raster frame with a ragged last line
  function automatic void queue_frame(int width, int height);
    int last, len;
    last = $urandom_range(1, width);
    for (int y = 0; y < height; y++) begin
      len = (y == height - 1) ? last : width;
      for (int x = 0; x < len; x++)
        push_px(pick_channel(band_lo[23:16], band_hi[23:16]),
                pick_channel(band_lo[15:8], band_hi[15:8]),
                pick_channel(band_lo[7:0], band_hi[7:0]),
                x == 0, (y == height - 1) && (x == len - 1));
    end
  endfunction

  // Random marks: stray line starts and early frame ends
  function automatic void queue_noise(int n);
    for (int i = 0; i < n; i++)
      push_px(8'($urandom), 8'($urandom), 8'($urandom),
              $urandom_range(3) == 0, $urandom_range(15) == 0);
  endfunction

  // Hold until every pixel is taken and every expected centroid has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || centroid_q.size() != 0);
  endtask

  // Drain, then let pixels without a result work through the pipeline
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      cwc_pkg::CFG_WIN_LEFT:   win_left = data[WIN_POS_W-1:0];
      cwc_pkg::CFG_WIN_TOP:    win_top = data[WIN_POS_W-1:0];
      cwc_pkg::CFG_WIN_SIZE:   win_size = data[WIN_SIZE_W-1:0];
      cwc_pkg::CFG_LOWER_BGR:  band_lo = data[BGR_W-1:0];
      cwc_pkg::CFG_UPPER_BGR:  band_hi = data[BGR_W-1:0];
      cwc_pkg::CFG_MIN_PIXELS: min_match = data[TALLY_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the write enable; return at a falling edge so pixels queue race-free
  task automatic close_regs();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write all registers, with junk above the window and minimum fields, plus the unmapped indexes
  task automatic load_config(logic [10:0] left, logic [10:0] top, logic [8:0] size,
                             logic [23:0] lo, logic [23:0] hi, logic [16:0] minp);
    set_reg(cwc_pkg::CFG_WIN_LEFT, {13'($urandom), left});
    set_reg(cwc_pkg::CFG_WIN_TOP, {13'($urandom), top});
    set_reg(cwc_pkg::CFG_WIN_SIZE, {15'($urandom), size});
    set_reg(cwc_pkg::CFG_LOWER_BGR, lo);
    set_reg(cwc_pkg::CFG_UPPER_BGR, hi);
    set_reg(cwc_pkg::CFG_MIN_PIXELS, {7'($urandom), minp});
    set_reg(CFG_SPARE_LO, 24'($urandom));
    set_reg(CFG_SPARE_HI, 24'($urandom));
    close_regs();
  endtask

  task automatic random_config(int phase);
    logic [10:0] left, top;
    logic [8:0]  size;
    logic [23:0] lo, hi;
    logic [16:0] minp;
    left = 11'($urandom_range(3));
    top  = 11'($urandom_range(3));
    size = 9'($urandom_range(1, 8));
    lo = {8'($urandom_range(90)), 8'($urandom_range(90)), 8'($urandom_range(90))};
    hi = {8'($urandom_range(255, 160)), 8'($urandom_range(255, 160)),
          8'($urandom_range(255, 160))};
    minp = 17'($urandom_range(6));
    case (phase)
      0: size = 9'd0;
      1: size = 9'h1FF;
      2: begin
        left = 11'h7FF;
        top  = 11'h7FF;
        size = 9'd256;
      end
      3: minp = 17'h1FFFF;
      4: begin
        lo = 24'hFFFFFF;
        hi = 24'hFFFFFF;
      end
      5: begin
        lo = 24'h000000;
        hi = 24'h000000;
      end
      6: begin
        lo = 24'($urandom);
        hi = 24'($urandom);
        left = 11'($urandom_range(8));
      end
      default: ;
    endcase
    load_config(left, top, size, lo, hi, minp);
  endtask

  initial begin : stimulus
    int phase, first_items, first_ends, n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: frame entirely outside the window, centre fallback
    push_px(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    push_px(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    quiesce();

    // 2x2 window at (1,1) in a 3x3 frame; channels at both bounds, each side failing
    load_config(11'd1, 11'd1, 9'd2, 24'h010101, 24'hFEFEFE, 17'd0);
    for (int x = 0; x < 3; x++) push_px(8'd128, 8'd128, 8'd128, x == 0, 1'b0);
    push_px(8'd128, 8'd128, 8'd128, 1'b1, 1'b0);
    push_px(8'd1, 8'd1, 8'd1, 1'b0, 1'b0);
    push_px(8'd254, 8'd254, 8'd254, 1'b0, 1'b0);
    push_px(8'd128, 8'd128, 8'd128, 1'b1, 1'b0);
    push_px(8'd0, 8'd128, 8'd128, 1'b0, 1'b0);
    push_px(8'd128, 8'd255, 8'd0, 1'b0, 1'b1);
    // Empty frame with zero minimum still reports not found
    push_px(8'd128, 8'd128, 8'd128, 1'b1, 1'b1);
    quiesce();

    // Shrink the window mid-frame so the centroid lands past the size
    load_config(11'd0, 11'd0, 9'd8, 24'h000000, 24'hFEFEFE, 17'd1);
    for (int y = 0; y < 3; y++) push_px(8'd7, 8'd7, 8'd255, 1'b1, 1'b0);
    push_px(8'd7, 8'd7, 8'd7, 1'b1, 1'b0);
    quiesce();
    set_reg(cwc_pkg::CFG_WIN_SIZE, 24'd2);
    close_regs();
    push_px(8'd7, 8'd7, 8'd7, 1'b0, 1'b1);

    // Random phases of small frames; each phase boundary holds the sender
    // until every expected centroid has arrived
    phase = 0;
    first_items = items_queued;
    first_ends = ends_queued;
    while (items_queued - first_items < RAND_ITEMS || ends_queued - first_ends < RAND_RESULTS)
    begin
      quiesce();
      calm = 1'b0;
      random_config(phase);
      if (phase == 5) calm = 1'b1;
      n = $urandom_range(3, 6);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0) queue_noise($urandom_range(1, 6));
        if ($urandom_range(9) == 0) queue_frame($urandom_range(1, 30), $urandom_range(1, 10));
        else queue_frame($urandom_range(1, 6), $urandom_range(1, 5));
        if (phase == 7 && k == 1) wait_drained();
      end
      phase++;
    end
    quiesce();
    calm = 1'b0;

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cwc_pkg.sv
hw/rtl/cwc_front.sv
hw/rtl/cwc_fifo.sv
hw/rtl/cwc_div.sv
hw/rtl/cwc_back.sv
hw/rtl/color_window_centroid.sv
tb/tb_top.sv
